@@ rtl/scfd_pkg.sv @@
// shared types and constants for the sum checked frame deframer
`default_nettype none
package scfd_pkg;

  localparam logic [7:0] SOF_BYTE  = 8'h68;
  localparam logic [7:0] EOF_BYTE  = 8'h16;
  localparam logic [7:0] TYPE_OFFS = 8'h80;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_TYPE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_CHECK = 2'd2;

  localparam logic [15:0] MAX_LEN_RST = 16'd1024;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_TYPE   = 3'd3,
    PH_DATA   = 3'd4,
    PH_CSUM   = 3'd5,
    PH_END    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CSUM_ERR = 3'd1,
    ST_END_ERR  = 3'd2,
    ST_LEN_ERR  = 3'd3,
    ST_TYPE_ERR = 3'd4
  } status_t;

endpackage
`default_nettype wire

@@ rtl/scfd_in_if.sv @@
// received byte channel
`default_nettype none
interface scfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/scfd_out_if.sv @@
// deframed result channel
`default_nettype none
interface scfd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] frame_type;
  logic [2:0] frame_status;
  logic       is_last;

  modport source (output valid, output kind, output payload_byte, output frame_type,
                  output frame_status, output is_last, input ready);
  modport sink (input valid, input kind, input payload_byte, input frame_type,
                input frame_status, input is_last, output ready);
endinterface
`default_nettype wire

@@ rtl/sum_checked_frame_deframer_unit.sv @@
// frame deframer top level: start byte hunt, length, type, payload, checksum, end byte
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+--------------------------------------------
//   in_ch    | in  | valid / ready | rx_byte
//   out_ch   | out | valid / ready | kind, payload_byte, frame_type,
//            |     |               | frame_status, is_last
//   cfg_*    | in  | cfg_we        | cfg_index, cfg_wdata
//
// one item per cycle; an item's result appears in the output register the cycle
// after it is taken. the phase register and one output register set this figure.
// in_ch.ready is high while the output register is empty or being drained, so
// a stall on out_ch holds off input only once a result is waiting.
// reset is synchronous: phase returns to hunting, config to its defaults.
`default_nettype none
module sum_checked_frame_deframer_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  scfd_in_if.sink                              in_ch,
  scfd_out_if.source                           out_ch,
  input  wire                                  cfg_we,
  input  wire [scfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [scfd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  // configuration
  logic [15:0] max_len_r;
  logic [7:0]  req_type_r;
  logic        type_check_r;

  // frame state
  scfd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  cur_type_r, cur_type_nxt;
  logic        matched_r, matched_nxt;

  // result register
  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_data_r;
  logic [7:0]  out_type_r;
  logic [2:0]  out_status_r;
  logic        out_last_r;

  // combinational result of the current item
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_data;
  logic [7:0]  res_type;
  scfd_pkg::status_t res_status;

  logic        in_acc;
  logic [7:0]  b;
  logic [15:0] full_len;
  logic [7:0]  want_type;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign full_len    = {len_hi_r, b};
  assign want_type   = req_type_r + scfd_pkg::TYPE_OFFS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= scfd_pkg::MAX_LEN_RST;
      req_type_r   <= '0;
      type_check_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scfd_pkg::CFG_MAX_LEN:    max_len_r    <= cfg_wdata;
        scfd_pkg::CFG_REQ_TYPE:   req_type_r   <= cfg_wdata[7:0];
        scfd_pkg::CFG_TYPE_CHECK: type_check_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= scfd_pkg::PH_HUNT;
      len_hi_r     <= '0;
      bytes_left_r <= '0;
      sum_r        <= '0;
      cur_type_r   <= '0;
      matched_r    <= 1'b0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      len_hi_r     <= len_hi_nxt;
      bytes_left_r <= bytes_left_nxt;
      sum_r        <= sum_nxt;
      cur_type_r   <= cur_type_nxt;
      matched_r    <= matched_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    len_hi_nxt     = len_hi_r;
    bytes_left_nxt = bytes_left_r;
    sum_nxt        = sum_r;
    cur_type_nxt   = cur_type_r;
    matched_nxt    = matched_r;
    res_valid      = 1'b0;
    res_kind       = scfd_pkg::KIND_DATA;
    res_data       = '0;
    res_type       = cur_type_r;
    res_status     = scfd_pkg::ST_OK;
    unique case (phase_r)
      scfd_pkg::PH_HUNT: begin
        if (b == scfd_pkg::SOF_BYTE) begin
          phase_nxt      = scfd_pkg::PH_LEN_HI;
          len_hi_nxt     = '0;
          bytes_left_nxt = '0;
          sum_nxt        = '0;
          cur_type_nxt   = '0;
          matched_nxt    = 1'b0;
        end
      end
      scfd_pkg::PH_LEN_HI: begin
        len_hi_nxt = b;
        phase_nxt  = scfd_pkg::PH_LEN_LO;
      end
      scfd_pkg::PH_LEN_LO: begin
        if (full_len > max_len_r) begin
          // type not seen yet, so it reads as zero
          phase_nxt  = scfd_pkg::PH_HUNT;
          res_valid  = 1'b1;
          res_kind   = scfd_pkg::KIND_STATUS;
          res_type   = '0;
          res_status = scfd_pkg::ST_LEN_ERR;
        end else begin
          bytes_left_nxt = full_len;
          phase_nxt      = scfd_pkg::PH_TYPE;
        end
      end
      scfd_pkg::PH_TYPE: begin
        cur_type_nxt = b;
        phase_nxt    = (bytes_left_r == '0) ? scfd_pkg::PH_CSUM : scfd_pkg::PH_DATA;
      end
      scfd_pkg::PH_DATA: begin
        sum_nxt        = sum_r + b;
        bytes_left_nxt = bytes_left_r - 16'd1;
        if (bytes_left_r == 16'd1) begin
          phase_nxt = scfd_pkg::PH_CSUM;
        end
        res_valid = 1'b1;
        res_data  = b;
      end
      scfd_pkg::PH_CSUM: begin
        matched_nxt = (b == sum_r);
        phase_nxt   = scfd_pkg::PH_END;
      end
      scfd_pkg::PH_END: begin
        phase_nxt = scfd_pkg::PH_HUNT;
        res_valid = 1'b1;
        res_kind  = scfd_pkg::KIND_STATUS;
        priority if (!matched_r) begin
          res_status = scfd_pkg::ST_CSUM_ERR;
        end else if (b != scfd_pkg::EOF_BYTE) begin
          res_status = scfd_pkg::ST_END_ERR;
        end else if (type_check_r && (cur_type_r != want_type)) begin
          res_status = scfd_pkg::ST_TYPE_ERR;
        end else begin
          res_status = scfd_pkg::ST_OK;
        end
      end
      default: begin
        phase_nxt = scfd_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_kind_r   <= res_kind;
      out_data_r   <= res_data;
      out_type_r   <= res_type;
      out_status_r <= res_status;
      out_last_r   <= res_kind;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.payload_byte = out_data_r;
  assign out_ch.frame_type   = out_type_r;
  assign out_ch.frame_status = out_status_r;
  assign out_ch.is_last      = out_last_r;

  // a waiting result is never overwritten by a new item
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten while stalled");

  // a frame closing status sends the block back to hunting
  a_hunt_after_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_valid && (res_kind == scfd_pkg::KIND_STATUS))
      |=> (phase_r == scfd_pkg::PH_HUNT))
    else $error("no return to hunting after frame status");

  // payload phase always has bytes still to come
  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == scfd_pkg::PH_DATA) |-> (bytes_left_r != '0))
    else $error("payload phase with zero bytes left");

  // payload results carry an ok status and no last flag
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == scfd_pkg::KIND_DATA))
      |-> (!out_last_r && (out_status_r == scfd_pkg::ST_OK)))
    else $error("payload result with status fields set");

endmodule
`default_nettype wire
